/* hw/rtl/sapq_pkg.sv */
`default_nettype none

package sapq_pkg;

  localparam int DEFAULT_CAPACITY = 8;

  localparam int KEY_W     = 16;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 4;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // Command broadcast to every cell of the chain in the cycle a transaction is taken.
  typedef struct packed {
    logic                        ins;
    logic                        rem;
    logic signed [KEY_W-1:0]     key;
    logic signed [PAYLOAD_W-1:0] payload;
  } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/sapq_cell.sv */
`default_nettype none

module sapq_cell
  import sapq_pkg::*;
(
  input  wire logic                        clk,
  input  wire cmd_t                        cmd,
  input  wire logic                        valid,
  input  wire logic                        left_stay,
  input  wire logic signed [KEY_W-1:0]     left_key,
  input  wire logic signed [PAYLOAD_W-1:0] left_payload,
  input  wire logic signed [KEY_W-1:0]     right_key,
  input  wire logic signed [PAYLOAD_W-1:0] right_payload,
  output logic                             stay,
  output logic signed [KEY_W-1:0]          key,
  output logic signed [PAYLOAD_W-1:0]      payload,
  output logic signed [KEY_W-1:0]          key_next,
  output logic signed [PAYLOAD_W-1:0]      payload_next
);

  // A held pair whose key is not above the new key keeps its place on insert.
  assign stay = valid && (key <= cmd.key);

  always_comb begin
    key_next     = key;
    payload_next = payload;
    if (cmd.ins) begin
      if (stay) begin
        key_next     = key;
        payload_next = payload;
      end else if (left_stay) begin
        key_next     = cmd.key;
        payload_next = cmd.payload;
      end else begin
        key_next     = left_key;
        payload_next = left_payload;
      end
    end else if (cmd.rem) begin
      key_next     = right_key;
      payload_next = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    key     <= key_next;
    payload <= payload_next;
  end

endmodule

`default_nettype wire

/* hw/rtl/sorted_array_priority_queue_core.sv */
// A result appears in the output register in the cycle after its transaction is taken.
// Throughput: one insert or remove per cycle while in_ready is high; every cell compares
// against the new key in parallel and shifts its neighbor's pair in the same cycle.
// Reset clears the pair count and the output valid flag; cell contents are not reset
// and are only read below the count.
`default_nettype none

module sorted_array_priority_queue_core
  import sapq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        kind,
  input  wire logic signed [KEY_W-1:0]     prio_key,
  input  wire logic signed [PAYLOAD_W-1:0] payload,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [STATUS_W-1:0]              status,
  output logic signed [PAYLOAD_W-1:0]      removed_payload,
  output logic signed [KEY_W-1:0]          removed_key,
  output logic signed [KEY_W-1:0]          head_key,
  output logic signed [PAYLOAD_W-1:0]      head_payload,
  output logic [OCC_W-1:0]                 occupancy,
  output logic                             is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic          accept;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          full;
  logic          empty;
  cmd_t          cmd;

  // Per-cell taps of the chain, each read at its own fixed place.
  logic                        cell_stay    [CAPACITY];
  logic signed [KEY_W-1:0]     cell_key     [CAPACITY];
  logic signed [PAYLOAD_W-1:0] cell_payload [CAPACITY];
  logic signed [KEY_W-1:0]     cell_key_n   [CAPACITY];
  logic signed [PAYLOAD_W-1:0] cell_pay_n   [CAPACITY];

  // The output register parts the two sides: a new transaction is taken whenever the
  // pending result is being collected or there is none.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    cmd.ins     = accept && (kind == KIND_INSERT) && !full;
    cmd.rem     = accept && (kind == KIND_REMOVE) && !empty;
    cmd.key     = prio_key;
    cmd.payload = payload;
  end

  // Cell zero sees a virtual left neighbor that always stays, so an insert that
  // passes no held pair lands at the head.
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                        l_stay;
      logic signed [KEY_W-1:0]     l_key;
      logic signed [PAYLOAD_W-1:0] l_payload;
      logic signed [KEY_W-1:0]     r_key;
      logic signed [PAYLOAD_W-1:0] r_payload;

      if (i == 0) begin : g_first
        assign l_stay    = 1'b1;
        assign l_key     = cell_key[i];
        assign l_payload = cell_payload[i];
      end else begin : g_mid
        assign l_stay    = cell_stay[i-1];
        assign l_key     = cell_key[i-1];
        assign l_payload = cell_payload[i-1];
      end

      // The last cell falls out of the valid range on a remove, so its own value
      // is as good as any.
      if (i == CAPACITY - 1) begin : g_last
        assign r_key     = cell_key[i];
        assign r_payload = cell_payload[i];
      end else begin : g_inner
        assign r_key     = cell_key[i+1];
        assign r_payload = cell_payload[i+1];
      end

      sapq_cell u_cell (
        .clk          (clk),
        .cmd          (cmd),
        .valid        (count > CW'(i)),
        .left_stay    (l_stay),
        .left_key     (l_key),
        .left_payload (l_payload),
        .right_key    (r_key),
        .right_payload(r_payload),
        .stay         (cell_stay[i]),
        .key          (cell_key[i]),
        .payload      (cell_payload[i]),
        .key_next     (cell_key_n[i]),
        .payload_next (cell_pay_n[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CW'(1);
    end else if (cmd.rem) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // The occupancy field keeps the low bits of the count only.
  logic [CW+OCC_W-1:0] count_wide;
  assign count_wide = {{OCC_W{1'b0}}, count_next};

  // Result register. Head fields come from the next contents of cell zero, which
  // is the head after this transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (kind == KIND_INSERT) begin
        status <= full ? ST_OVERFLOW : ST_OK;
      end else begin
        status <= empty ? ST_UNDERFLOW : ST_OK;
      end
      removed_key     <= cmd.rem ? cell_key[0] : '0;
      removed_payload <= cmd.rem ? cell_payload[0] : '0;
      head_key        <= (count_next != '0) ? cell_key_n[0] : '0;
      head_payload    <= (count_next != '0) ? cell_pay_n[0] : '0;
      occupancy       <= count_wide[OCC_W-1:0];
      is_empty        <= (count_next == '0);
    end
  end

endmodule

`default_nettype wire
